### rtl/core/b64d_pkg.sv
// Shared types, constants and the character classifier of the Base64 stream decoder.
`default_nettype none

package b64d_pkg;

    // Character and code constants.
    localparam logic [7:0] PAD_CHAR     = 8'h3D;
    localparam logic [6:0] INVALID_CODE = 7'd64;
    localparam logic [1:0] LAST_POS     = 2'd3;
    localparam logic [1:0] FULL_COUNT   = 2'd3;

    // Status codes carried by the end-of-text result.
    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_BAD_LENGTH = 2'd1;
    localparam logic [1:0] STATUS_BAD_CHAR   = 2'd2;

    // Work handed from the front end to the output sequencer.
    typedef struct packed {
        logic [23:0] word;
        logic [1:0]  byte_count;
        logic        has_status;
        logic [1:0]  status;
    } t_job;

    // Map one byte to its sextet; bytes outside the alphabet give the invalid code.
    function automatic logic [6:0] sextet_of(input logic [7:0] c);
        logic [6:0] code;
        if (c >= 8'h41 && c <= 8'h5A) begin
            code = 7'(c - 8'h41);
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            code = 7'(c - 8'd71);
        end else if (c >= 8'h30 && c <= 8'h39) begin
            code = 7'(c + 8'd4);
        end else if (c == 8'h2B) begin
            code = 7'd62;
        end else if (c == 8'h2F) begin
            code = 7'd63;
        end else if (c == PAD_CHAR) begin
            code = 7'd0;
        end else begin
            code = INVALID_CODE;
        end
        return code;
    endfunction

endpackage

`default_nettype wire

### rtl/core/b64d_front.sv
// Front end: classifies each character, assembles quartets and issues output jobs.
`default_nettype none

module b64d_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_write,
    input  wire logic          i_cfg_check_alphabet,
    input  wire logic          i_accept,
    input  wire logic [7:0]    i_char_code,
    input  wire logic          i_end_of_text,
    output      logic          o_push,
    output      b64d_pkg::t_job o_job
);

    logic       r_check;
    logic [1:0] r_pos;
    logic       r_third;
    logic       r_bad;
    logic       r_err;
    logic [6:0] r_buf [3];

    logic [1:0] n_pos;
    logic       n_third;
    logic       n_bad;
    logic       n_err;

    logic [6:0] code;
    logic       is_pad;
    logic       bad_now;
    logic [23:0] word;
    logic [1:0] count;

    // Classify the character and work out the quartet's next state.
    always_comb begin
        code    = b64d_pkg::sextet_of(i_char_code);
        is_pad  = (i_char_code == b64d_pkg::PAD_CHAR);
        bad_now = r_bad | (code == b64d_pkg::INVALID_CODE);
        // Invalid codes are ORed in as is; bit 6 of the first sextet falls off the word.
        word    = (24'(r_buf[0]) << 18) | (24'(r_buf[1]) << 12)
                | (24'(r_buf[2]) << 6) | 24'(code);
        n_pos   = r_pos;
        n_third = r_third;
        n_bad   = bad_now;
        n_err   = r_err;
        count   = 2'd0;
        if (r_pos != b64d_pkg::LAST_POS) begin
            n_pos = r_pos + 2'd1;
            if (r_pos == 2'd2) begin
                n_third = is_pad;
            end
        end else begin
            n_pos   = 2'd0;
            n_bad   = 1'b0;
            n_third = 1'b0;
            if (!r_err) begin
                if (r_check && bad_now) begin
                    n_err = 1'b1;
                end else begin
                    count = b64d_pkg::FULL_COUNT
                          - ((i_end_of_text && r_third) ? 2'd1 : 2'd0)
                          - ((i_end_of_text && is_pad) ? 2'd1 : 2'd0);
                end
            end
        end
    end

    // Build the job; a status job is issued on the final character.
    always_comb begin
        o_job.word       = word;
        o_job.byte_count = count;
        o_job.has_status = i_end_of_text;
        if (n_pos != 2'd0) begin
            o_job.status = b64d_pkg::STATUS_BAD_LENGTH;
        end else if (n_err) begin
            o_job.status = b64d_pkg::STATUS_BAD_CHAR;
        end else begin
            o_job.status = b64d_pkg::STATUS_OK;
        end
        o_push = i_accept && ((count != 2'd0) || i_end_of_text);
    end

    // Control state; the final character returns the stream state to idle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_check <= 1'b1;
            r_pos   <= 2'd0;
            r_third <= 1'b0;
            r_bad   <= 1'b0;
            r_err   <= 1'b0;
        end else begin
            if (i_cfg_write) begin
                r_check <= i_cfg_check_alphabet;
            end
            if (i_accept) begin
                if (i_end_of_text) begin
                    r_pos   <= 2'd0;
                    r_third <= 1'b0;
                    r_bad   <= 1'b0;
                    r_err   <= 1'b0;
                end else begin
                    r_pos   <= n_pos;
                    r_third <= n_third;
                    r_bad   <= n_bad;
                    r_err   <= n_err;
                end
            end
        end
    end

    // Sextet buffer; every entry is written before the quartet reads it.
    always_ff @(posedge i_clk) begin
        if (i_accept && r_pos != b64d_pkg::LAST_POS) begin
            r_buf[r_pos] <= code;
        end
    end

endmodule

`default_nettype wire

### rtl/core/b64d_queue.sv
// Job queue between the front end and the output sequencer.
`default_nettype none

module b64d_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire b64d_pkg::t_job i_job,
    output      logic           o_full,
    input  wire logic           i_pop,
    output      logic           o_valid,
    output      b64d_pkg::t_job o_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    b64d_pkg::t_job r_slot [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_slot[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Job storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr] <= i_job;
        end
    end

endmodule

`default_nettype wire

### rtl/core/b64d_back.sv
// Output sequencer: turns each job into byte and status items behind an output register.
`default_nettype none

module b64d_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_job_valid,
    input  wire b64d_pkg::t_job i_job,
    output      logic           o_pop,
    output      logic           o_out_valid,
    input  wire logic           i_out_ready,
    output      logic [7:0]     o_out_byte,
    output      logic           o_is_status,
    output      logic [1:0]     o_status_code,
    output      logic           o_last_of_run
);

    logic           r_busy;
    b64d_pkg::t_job r_job;
    logic [1:0]     r_sent;
    logic           r_out_valid;
    logic [7:0]     r_byte;
    logic           r_is_status;
    logic [1:0]     r_status;
    logic           r_last;

    logic       advance;
    logic       sending_byte;
    logic       job_done;
    logic [7:0] sel_byte;

    assign advance      = !r_out_valid || i_out_ready;
    assign sending_byte = (r_sent < r_job.byte_count);
    assign job_done     = sending_byte
                        ? ((r_sent == r_job.byte_count - 2'd1) && !r_job.has_status)
                        : 1'b1;
    // A new job is loaded when idle or when the current one sends its final item.
    assign o_pop        = i_job_valid && (!r_busy || (advance && job_done));

    // Byte lane select, most significant byte first.
    always_comb begin
        case (r_sent)
            2'd0:    sel_byte = r_job.word[23:16];
            2'd1:    sel_byte = r_job.word[15:8];
            default: sel_byte = r_job.word[7:0];
        endcase
    end

    // Sequencer control and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_sent      <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_out_valid <= r_busy;
            end
            if (r_busy && advance && !job_done) begin
                r_sent <= r_sent + 2'd1;
            end else if (!r_busy || (advance && job_done)) begin
                r_busy <= i_job_valid;
                r_sent <= 2'd0;
            end
        end
    end

    // Job and output payload.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
        if (advance && r_busy) begin
            r_byte      <= sending_byte ? sel_byte : 8'd0;
            r_is_status <= !sending_byte;
            r_status    <= sending_byte ? b64d_pkg::STATUS_OK : r_job.status;
            r_last      <= job_done;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_byte    = r_byte;
    assign o_is_status   = r_is_status;
    assign o_status_code = r_status;
    assign o_last_of_run = r_last;

endmodule

`default_nettype wire

### rtl/core/base64_stream_decoder_top.sv
// Top level of the Base64 stream decoder.
`default_nettype none

// Base64 (standard alphabet) decoder taking one character item per clock
// while its queue has room. Every fourth character yields three byte items,
// fewer in a final quartet with '=' padding, none once checking has found an
// invalid character; the character flagged end_of_text is followed by one
// status item (0 ok, 1 length not a multiple of four, 2 invalid character).
// The output side delivers one item per cycle while i_out_ready is high. The
// front end classifies characters and queues output jobs in a queue of
// QUEUE_DEPTH entries, so input stalls only when that queue is full.
// check_alphabet (reset 1) is written through the configuration channel and
// is always ready; write it only while the decoder is idle.
module base64_stream_decoder_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_valid,
    output      logic       o_cfg_ready,
    input  wire logic       i_cfg_check_alphabet,
    input  wire logic       i_in_valid,
    output      logic       o_in_ready,
    input  wire logic [7:0] i_char_code,
    input  wire logic       i_end_of_text,
    output      logic       o_out_valid,
    input  wire logic       i_out_ready,
    output      logic [7:0] o_out_byte,
    output      logic       o_is_status,
    output      logic [1:0] o_status_code,
    output      logic       o_last_of_run
);

    logic           accept;
    logic           push;
    b64d_pkg::t_job front_job;
    logic           q_full;
    logic           q_valid;
    logic           pop;
    b64d_pkg::t_job q_job;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !q_full;
    assign accept      = i_in_valid && !q_full;

    b64d_front u_front (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_write          (i_cfg_valid),
        .i_cfg_check_alphabet (i_cfg_check_alphabet),
        .i_accept             (accept),
        .i_char_code          (i_char_code),
        .i_end_of_text        (i_end_of_text),
        .o_push               (push),
        .o_job                (front_job)
    );

    b64d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_job   (q_job)
    );

    b64d_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job_valid   (q_valid),
        .i_job         (q_job),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_byte    (o_out_byte),
        .o_is_status   (o_is_status),
        .o_status_code (o_status_code),
        .o_last_of_run (o_last_of_run)
    );

endmodule

`default_nettype wire
